FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared operation codes, widths and control types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned DIV_STEPS = 4;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_GT       = 4'd6,
		OP_LT       = 4'd7,
		OP_GE       = 4'd8,
		OP_LE       = 4'd9,
		OP_EQ       = 4'd10,
		OP_NE       = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	typedef struct packed {
		logic neg;
		logic dz;
	} div_ctrl_t;

endpackage

FILE: rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels carrying ALU requests and results.
// ----------------------------------------------------------------------------
interface fpa_req_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  req_type;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, output req_type, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input req_type, input operand_a, input operand_b,
		output ready);
endinterface

interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic               divide_error;

	modport source (output valid, output result_value, output compare_true,
		output divide_error, input ready);
	modport sink (input valid, input result_value, input compare_true,
		input divide_error, output ready);
endinterface

FILE: rtl/fpa_delay.sv
// ----------------------------------------------------------------------------
// fpa_delay
// Enable-gated register line that keeps side results aligned with the divider.
// ----------------------------------------------------------------------------
module fpa_delay #(
	parameter int unsigned W = 1,
	parameter int unsigned N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(N); i++) begin
				line_q[i] <= '0;
			end
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < int'(N); i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

FILE: rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Two-stage signed multiply with truncation toward zero of the fraction.
// ----------------------------------------------------------------------------
module fpa_mul
	import fpa_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WORD_W-1:0] a,
	input  logic signed [WORD_W-1:0] b,
	output logic        [WORD_W-1:0] prod
);

	localparam logic [63:0] ROUND_ADD = (64'd1 << FRACTION_BITS) - 64'd1;

	logic signed [63:0] prod_s1;
	logic        [63:0] adj;
	logic [WORD_W-1:0]  prod_s2;

	assign adj = 64'(prod_s1) + (prod_s1[63] ? ROUND_ADD : 64'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(a) * 64'(b);
			prod_s2 <= adj[FRACTION_BITS +: WORD_W];
		end
	end

	assign prod = prod_s2;

endmodule

FILE: rtl/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// One pipeline stage of the restoring divider, STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module fpa_div_stage
	import fpa_pkg::*;
#(
	parameter int unsigned QB    = 40,
	parameter int unsigned STEPS = 4
) (
	input  logic              clk,
	input  logic              en,
	input  logic [QB-1:0]     num_in,
	input  logic [WORD_W-1:0] rem_in,
	input  logic [WORD_W-1:0] den_in,
	input  logic [WORD_W-1:0] quo_in,
	input  div_ctrl_t         ctrl_in,
	output logic [QB-1:0]     num_out,
	output logic [WORD_W-1:0] rem_out,
	output logic [WORD_W-1:0] den_out,
	output logic [WORD_W-1:0] quo_out,
	output div_ctrl_t         ctrl_out
);

	logic [QB-1:0]     num_c;
	logic [WORD_W:0]   part_c;
	logic [WORD_W-1:0] rem_c;
	logic [WORD_W-1:0] quo_c;

	always_comb begin
		num_c  = num_in;
		rem_c  = rem_in;
		quo_c  = quo_in;
		part_c = '0;
		for (int i = 0; i < int'(STEPS); i++) begin
			part_c = {rem_c, num_c[QB-1]};
			num_c  = {num_c[QB-2:0], 1'b0};
			if (part_c >= {1'b0, den_in}) begin
				part_c = part_c - {1'b0, den_in};
				quo_c  = {quo_c[WORD_W-2:0], 1'b1};
			end else begin
				quo_c  = {quo_c[WORD_W-2:0], 1'b0};
			end
			rem_c = part_c[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out  <= num_c;
			rem_out  <= rem_c;
			den_out  <= den_in;
			quo_out  <= quo_c;
			ctrl_out <= ctrl_in;
		end
	end

endmodule

FILE: rtl/fpa_divider.sv
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined magnitude divider of (a << FRACTION_BITS) by b, low quotient word.
// ----------------------------------------------------------------------------
module fpa_divider
	import fpa_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WORD_W-1:0] a,
	input  logic signed [WORD_W-1:0] b,
	output logic        [WORD_W-1:0] quo_mag,
	output div_ctrl_t                ctrl
);

	localparam int unsigned QB  = WORD_W + FRACTION_BITS;
	localparam int unsigned NST = (QB + DIV_STEPS - 1) / DIV_STEPS;

	logic [QB-1:0]     num_w  [NST+1];
	logic [WORD_W-1:0] rem_w  [NST+1];
	logic [WORD_W-1:0] den_w  [NST+1];
	logic [WORD_W-1:0] quo_w  [NST+1];
	div_ctrl_t         ctrl_w [NST+1];

	logic [WORD_W-1:0] a_mag;
	logic [WORD_W-1:0] b_mag;

	assign a_mag = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
	assign b_mag = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);

	// prep stage
	always_ff @(posedge clk) begin
		if (en) begin
			num_w[0]      <= {a_mag, {FRACTION_BITS{1'b0}}};
			rem_w[0]      <= '0;
			den_w[0]      <= b_mag;
			quo_w[0]      <= '0;
			ctrl_w[0].neg <= a[WORD_W-1] ^ b[WORD_W-1];
			ctrl_w[0].dz  <= (b == '0);
		end
	end

	for (genvar k = 0; k < int'(NST); k++) begin : g_stage
		localparam int unsigned STEPS_K =
			(k == int'(NST) - 1) ? (QB - (NST - 1) * DIV_STEPS) : DIV_STEPS;
		fpa_div_stage #(
			.QB    (QB),
			.STEPS (STEPS_K)
		) u_stage (
			.clk      (clk),
			.en       (en),
			.num_in   (num_w[k]),
			.rem_in   (rem_w[k]),
			.den_in   (den_w[k]),
			.quo_in   (quo_w[k]),
			.ctrl_in  (ctrl_w[k]),
			.num_out  (num_w[k+1]),
			.rem_out  (rem_w[k+1]),
			.den_out  (den_w[k+1]),
			.quo_out  (quo_w[k+1]),
			.ctrl_out (ctrl_w[k+1])
		);
	end

	assign quo_mag = quo_w[NST];
	assign ctrl    = ctrl_w[NST];

endmodule

FILE: rtl/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU, 32-bit raw words with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (req_type, operand_a, operand_b) and one
// result beat per request leaves on the rsp channel (result_value,
// compare_true, divide_error), in request order.
// The path from accepted request to result beat is one input register, one
// divider prep register, NST divider stages and one output register, where
// NST = ceil((32 + FRACTION_BITS) / 4); each stage takes four quotient bits,
// the last fewer when 32 + FRACTION_BITS is not a multiple of four. Every
// operation takes the same path length so results stay ordered.
// Throughput is one request per cycle while the receiver does not stall; the
// restoring divider is fully pipelined and the multiplier is a registered
// 32x32 product. When the receiver stalls with a result waiting, the whole
// pipeline holds and req.ready drops; nothing is lost or repeated. If the
// output register is empty the pipeline keeps moving regardless of rsp.ready.
// Reset clears all valid bits; the unit accepts a request as soon as reset
// is released.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit
	import fpa_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);

	localparam int unsigned QB  = WORD_W + FRACTION_BITS;
	localparam int unsigned NST = (QB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int unsigned DLY = NST + 1;
	localparam logic [63:0] ROUND_ADD = (64'd1 << FRACTION_BITS) - 64'd1;

	logic                     en;
	logic                     valid_s1;
	logic [3:0]               op_s1;
	logic signed [WORD_W-1:0] a_s1;
	logic signed [WORD_W-1:0] b_s1;

	logic [WORD_W-1:0] simple_res;
	logic              simple_cmp;
	logic [63:0]       to_int_sum;

	logic [WORD_W:0]   simple_dly;
	logic [WORD_W-1:0] mul_res;
	logic [WORD_W-1:0] mul_dly;
	logic [WORD_W-1:0] quo_mag;
	div_ctrl_t         div_ctrl;
	logic [4:0]        tag_dly;
	op_t               op_end;

	logic              rsp_valid_q;
	logic [WORD_W-1:0] rsp_value_q;
	logic              rsp_cmp_q;
	logic              rsp_derr_q;
	logic [WORD_W-1:0] value_c;
	logic              cmp_c;
	logic              derr_c;

	assign en        = !rsp_valid_q || rsp.ready;
	assign req.ready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= req.req_type;
			a_s1  <= req.operand_a;
			b_s1  <= req.operand_b;
		end
	end

	// combinational operations
	assign to_int_sum = 64'(a_s1) + (a_s1[WORD_W-1] ? ROUND_ADD : 64'd0);

	always_comb begin
		simple_res = '0;
		simple_cmp = 1'b0;
		unique case (op_t'(op_s1))
			OP_ADD:      simple_res = WORD_W'(a_s1 + b_s1);
			OP_SUB:      simple_res = WORD_W'(a_s1 - b_s1);
			OP_MIN:      simple_res = (a_s1 <= b_s1) ? a_s1 : b_s1;
			OP_MAX:      simple_res = (a_s1 >= b_s1) ? a_s1 : b_s1;
			OP_GT:       simple_cmp = (a_s1 > b_s1);
			OP_LT:       simple_cmp = (a_s1 < b_s1);
			OP_GE:       simple_cmp = (a_s1 >= b_s1);
			OP_LE:       simple_cmp = (a_s1 <= b_s1);
			OP_EQ:       simple_cmp = (a_s1 == b_s1);
			OP_NE:       simple_cmp = (a_s1 != b_s1);
			OP_INC:      simple_res = WORD_W'(a_s1 + 32'sd1);
			OP_DEC:      simple_res = WORD_W'(a_s1 - 32'sd1);
			OP_FROM_INT: simple_res = WORD_W'(a_s1 << FRACTION_BITS);
			OP_TO_INT:   simple_res = to_int_sum[FRACTION_BITS +: WORD_W];
			OP_MUL, OP_DIV: simple_res = '0;
			default:     simple_res = '0;
		endcase
	end

	fpa_delay #(
		.W (WORD_W + 1),
		.N (DLY)
	) u_simple_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({simple_cmp, simple_res}),
		.q      (simple_dly)
	);

	fpa_mul #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk  (clk),
		.en   (en),
		.a    (a_s1),
		.b    (b_s1),
		.prod (mul_res)
	);

	fpa_delay #(
		.W (WORD_W),
		.N (DLY - 2)
	) u_mul_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (mul_res),
		.q      (mul_dly)
	);

	fpa_divider #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.en      (en),
		.a       (a_s1),
		.b       (b_s1),
		.quo_mag (quo_mag),
		.ctrl    (div_ctrl)
	);

	// valid and opcode travel alongside the divider
	fpa_delay #(
		.W (5),
		.N (DLY)
	) u_tag_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({valid_s1, op_s1}),
		.q      (tag_dly)
	);

	assign op_end = op_t'(tag_dly[3:0]);

	always_comb begin
		value_c = simple_dly[WORD_W-1:0];
		cmp_c   = simple_dly[WORD_W];
		derr_c  = 1'b0;
		if (op_end == OP_MUL) begin
			value_c = mul_dly;
		end else if (op_end == OP_DIV) begin
			derr_c  = div_ctrl.dz;
			value_c = div_ctrl.dz ? '0 : (div_ctrl.neg ? WORD_W'(-quo_mag) : quo_mag);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= tag_dly[4];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_value_q <= value_c;
			rsp_cmp_q   <= cmp_c;
			rsp_derr_q  <= derr_c;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.compare_true = rsp_cmp_q;
	assign rsp.divide_error = rsp_derr_q;

	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_error |-> rsp.result_value == '0 && !rsp.compare_true)
		else $error("divide error beat with nonzero result");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req.ready)
		else $error("pipeline stalled with empty output");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request lost at input stage");

endmodule

FILE: sim/tb_fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_unit
// Self-checking bench for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
// A short table of directed requests covers every operation, the word
// extremes, wrap-around, a min tie and divide by zero, then a long run of
// random requests follows. Every result beat is compared field by field with
// the oldest outstanding expectation, which comes from the table where it is
// obvious and from a behavioural model of the ALU otherwise. Both channels
// idle at random, and the sender drains the unit once mid-run.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_unit;
	import fpa_pkg::*;

	localparam int unsigned FRAC       = 8;
	localparam int unsigned STALL_MAX  = 4;
	localparam int unsigned N_RANDOM   = 430;
	localparam int unsigned DRAIN_WAIT = 40;
	localparam int unsigned WD_LIMIT   = 2000;
	localparam int unsigned SHOW_MAX   = 20;

	typedef struct packed {
		logic signed [31:0] value;
		logic               cmp;
		logic               dz;
	} alu_res_t;

	typedef struct {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 known;
		alu_res_t           res;
	} vec_t;

	logic clk;
	logic arst_n;

	fpa_req_if req ();
	fpa_rsp_if rsp ();

	fixed_point_alu_unit #(.FRACTION_BITS(FRAC)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	alu_res_t    pending_res[$];
	vec_t        vectors[$];
	bit          cur_known;
	alu_res_t    cur_res;
	int unsigned n_fail;
	int unsigned n_beats;
	int unsigned n_div_zero;
	int unsigned op_count[16];
	int unsigned idle_cycles;
	bit          rx_quiet;
	int unsigned rx_stall;

	function automatic alu_res_t alu_model(op_t op, logic signed [31:0] a,
			logic signed [31:0] b);
		longint   sa;
		longint   sb;
		longint   scale;
		longint   v;
		alu_res_t r;
		sa    = a;
		sb    = b;
		scale = longint'(1) << FRAC;
		v     = 0;
		r     = '0;
		case (op)
			OP_ADD:      v = sa + sb;
			OP_SUB:      v = sa - sb;
			OP_MUL:      v = (sa * sb) / scale;
			OP_DIV: begin
				if (sb == 0) r.dz = 1'b1;
				else v = (sa * scale) / sb;
			end
			OP_MIN:      v = (sa <= sb) ? sa : sb;
			OP_MAX:      v = (sa >= sb) ? sa : sb;
			OP_GT:       r.cmp = sa > sb;
			OP_LT:       r.cmp = sa < sb;
			OP_GE:       r.cmp = sa >= sb;
			OP_LE:       r.cmp = sa <= sb;
			OP_EQ:       r.cmp = sa == sb;
			OP_NE:       r.cmp = sa != sb;
			OP_INC:      v = sa + 1;
			OP_DEC:      v = sa - 1;
			OP_FROM_INT: v = sa * scale;
			default:     v = sa / scale;
		endcase
		r.value = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return 32'(signed'($urandom_range(0, 2048)) - 1024);
			3:       return 32'(signed'($urandom_range(0, 16)) - 8) <<< FRAC;
			4:       return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_vec(op_t op, logic signed [31:0] a, logic signed [31:0] b,
			bit known, logic signed [31:0] value, logic cmp, logic dz);
		vec_t v;
		v.op    = op;
		v.a     = a;
		v.b     = b;
		v.known = known;
		v.res   = '{value, cmp, dz};
		vectors.push_back(v);
	endtask

	task automatic send_beat(vec_t v, bit no_gap);
		int unsigned gap;
		gap = no_gap ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.req_type  <= v.op;
		req.operand_a <= v.a;
		req.operand_b <= v.b;
		cur_known     <= v.known;
		cur_res       <= v.res;
		op_count[v.op]++;
		do @(posedge clk); while (!req.ready);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request acceptance
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			if (cur_known) pending_res.push_back(cur_res);
			else pending_res.push_back(alu_model(op_t'(req.req_type), req.operand_a,
				req.operand_b));
		end
	end

	// result sink with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_stall  <= 0;
			rx_quiet  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if ($urandom_range(0, 49) == 0) rx_quiet <= ~rx_quiet;
				rx_stall  <= rx_quiet ? 0 : $urandom_range(0, STALL_MAX);
				rsp.ready <= rx_quiet || ($urandom_range(0, STALL_MAX) == 0);
			end else if (rx_stall > 0) begin
				rx_stall  <= rx_stall - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		alu_res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_beats++;
			if (pending_res.size() == 0) begin
				n_fail++;
				if (n_fail <= SHOW_MAX)
					$display("%0t: unexpected result beat value=%h", $time, rsp.result_value);
			end else begin
				want = pending_res.pop_front();
				if (want.dz) n_div_zero++;
				if (rsp.result_value !== want.value || rsp.compare_true !== want.cmp ||
						rsp.divide_error !== want.dz) begin
					n_fail++;
					if (n_fail <= SHOW_MAX)
						$display("%0t: mismatch expected value=%h cmp=%b dz=%b got value=%h cmp=%b dz=%b",
							$time, want.value, want.cmp, want.dz, rsp.result_value,
							rsp.compare_true, rsp.divide_error);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					pending_res.size());
				$display("** fixed_point_alu_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		vec_t v;
		bit   burst;
		req.valid     <= 1'b0;
		req.req_type  <= OP_ADD;
		req.operand_a <= '0;
		req.operand_b <= '0;
		cur_known     <= 1'b0;
		cur_res       <= '0;
		burst         = 1'b0;
		arst_n        = 1'b0;

		add_vec(OP_ADD, 32'sh7fff_ffff, 1, 1, 32'sh8000_0000, 0, 0);
		add_vec(OP_SUB, 32'sh8000_0000, 1, 1, 32'sh7fff_ffff, 0, 0);
		add_vec(OP_MUL, 32'sh0000_0200, 32'sh0000_0300, 1, 32'sh0000_0600, 0, 0);
		add_vec(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
		add_vec(OP_MUL, -32'sd1, 32'sd1, 1, 0, 0, 0);
		add_vec(OP_DIV, 32'sh0000_0100, 0, 1, 0, 0, 1);
		add_vec(OP_DIV, 32'sh8000_0000, 0, 1, 0, 0, 1);
		add_vec(OP_DIV, 32'sh8000_0000, -32'sd1, 0, 0, 0, 0);
		add_vec(OP_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0);
		add_vec(OP_DIV, -32'sh0000_0300, 32'sh0000_0200, 1, -32'sh0000_0180, 0, 0);
		add_vec(OP_MIN, 32'sd5, 32'sd5, 1, 32'sd5, 0, 0);
		add_vec(OP_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 0, 0);
		add_vec(OP_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh8000_0000, 0, 0);
		add_vec(OP_GT, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0, 1, 0);
		add_vec(OP_LT, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0, 0, 0);
		add_vec(OP_GE, 32'sd7, 32'sd7, 1, 0, 1, 0);
		add_vec(OP_LE, 32'sd7, 32'sd7, 1, 0, 1, 0);
		add_vec(OP_EQ, -32'sd1, -32'sd1, 1, 0, 1, 0);
		add_vec(OP_NE, -32'sd1, -32'sd1, 1, 0, 0, 0);
		add_vec(OP_INC, 32'sh7fff_ffff, -32'sd1, 1, 32'sh8000_0000, 0, 0);
		add_vec(OP_DEC, 32'sh8000_0000, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 0, 0);
		add_vec(OP_FROM_INT, 32'sh0100_0000, 0, 1, 0, 0, 0);
		add_vec(OP_FROM_INT, -32'sd3, 0, 1, -32'sh0000_0300, 0, 0);
		add_vec(OP_TO_INT, -32'sd1, 0, 1, 0, 0, 0);
		add_vec(OP_TO_INT, 32'sh8000_0000, 0, 1, 32'shff80_0000, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) send_beat(vectors[i], 1'b0);

		for (int unsigned n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				req.valid <= 1'b0;
				wait (pending_res.size() == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 29) == 0) burst = ~burst;
			v.op    = op_t'($urandom_range(0, 15));
			v.a     = rand_operand();
			v.b     = ((v.op == OP_DIV) && $urandom_range(0, 7) == 0) ? 0 : rand_operand();
			if ((v.op inside {[OP_MIN:OP_NE]}) && $urandom_range(0, 3) == 0) v.b = v.a;
			v.known = 1'b0;
			v.res   = '0;
			send_beat(v, burst);
		end
		req.valid <= 1'b0;

		wait (pending_res.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run covered %0d result beats over all 16 operations, %0d divides by zero",
			n_beats, n_div_zero);
		$display("directed extremes, wrap-around and ties, then random operands with idle gaps");
		if (n_fail == 0 && pending_res.size() == 0) begin
			$display("** fixed_point_alu_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results outstanding", n_fail, pending_res.size());
			$display("** fixed_point_alu_unit: FAILED **");
		end
		$finish;
	end

endmodule
